// ===== src/ritoa_pkg.sv =====
// Package for the radix integer-to-ASCII converter: sizes, item and result
// structs, sequencer states and the digit-to-character function.
// No dependencies.
`timescale 1ns / 1ps

package ritoa_pkg;

  // Sizes
  localparam int VALUE_WIDTH   = 64;
  localparam int MAX_DIGITS    = 64;
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int DIV_W         = DIV_STEPS * BITS_PER_STEP;
  localparam int STEP_W        = $clog2(DIV_STEPS + 1);
  localparam int ADDR_W        = $clog2(MAX_DIGITS);
  localparam int DIGIT_W       = 4;
  localparam int RADIX_W       = 5;

  // Radix limits and character codes
  localparam logic [7:0] RADIX_MIN    = 8'd2;
  localparam logic [7:0] RADIX_MAX    = 8'd16;
  localparam logic [3:0] DEC_LIMIT    = 4'd10;
  localparam logic [6:0] CHAR_ZERO    = 7'h30;
  localparam logic [6:0] CHAR_UPPER_A = 7'h41;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_NONE    = 7'h00;

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  radix;
    logic        caps;
    logic        unsigned_mode;
  } item_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       last_digit;
    logic       bad_radix;
  } result_t;

  typedef struct packed {
    logic start;  // begin one digit division
    logic load;   // with start: take a new dividend
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;       // quotient and remainder final this cycle
    logic quot_zero;
  } div_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_e;

  // Map one digit to its ASCII code
  function automatic logic [6:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                input logic upper);
    logic [6:0] letter;
    letter = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < DEC_LIMIT) begin
      return CHAR_ZERO + {3'b000, d};
    end
    return letter + {3'b000, d} - {3'b000, DEC_LIMIT};
  endfunction

endpackage

// ===== src/ritoa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ritoa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ritoa_div.sv =====
// Iterative divider by a small radix: BITS_PER_STEP restoring steps a cycle.
// The quotient stays in place so the next digit divides it again.
// Depends on ritoa_pkg.
`timescale 1ns / 1ps

module ritoa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ritoa_pkg::div_ctrl_t        ctrl_i,
  input  logic [ritoa_pkg::DIV_W-1:0] value_i,
  input  logic [ritoa_pkg::RADIX_W-1:0] radix_i,
  output ritoa_pkg::div_status_t      status_o,
  output logic [ritoa_pkg::DIGIT_W-1:0] rem_o
);

  logic [ritoa_pkg::DIV_W-1:0]   acc_q, acc_d;
  logic [ritoa_pkg::DIGIT_W-1:0] rem_q, rem_d;
  logic [ritoa_pkg::STEP_W-1:0]  step_q;
  logic                          busy_q, done_q;
  logic                          last_step;

  assign last_step = (step_q == ritoa_pkg::STEP_W'(ritoa_pkg::DIV_STEPS - 1));

  // Shift dividend bits into the remainder, quotient bits into the low end
  always_comb begin
    logic [ritoa_pkg::RADIX_W-1:0] part;
    logic                          qbit;
    acc_d = acc_q;
    rem_d = rem_q;
    for (int i = 0; i < ritoa_pkg::BITS_PER_STEP; i++) begin
      part = {rem_d, acc_d[ritoa_pkg::DIV_W-1]};
      qbit = (part >= radix_i);
      rem_d = qbit ? ritoa_pkg::DIGIT_W'(part - radix_i)
                   : part[ritoa_pkg::DIGIT_W-1:0];
      acc_d = {acc_d[ritoa_pkg::DIV_W-2:0], qbit};
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start && ctrl_i.load) begin
      acc_q <= value_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.start) begin
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
    end
  end

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        busy_q <= !last_step;
        step_q <= step_q + 1'b1;
      end
    end
  end

  assign status_o.busy      = busy_q;
  assign status_o.done      = done_q;
  assign status_o.quot_zero = (acc_q == '0);
  assign rem_o              = rem_q;

endmodule

// ===== src/radix_integer_to_ascii_top.sv =====
// Top level of the radix integer-to-ASCII converter: sequencer, digit store
// and result register. Depends on ritoa_pkg, ritoa_div and ritoa_ram.
`timescale 1ns / 1ps

//  channel  | ports                         | transfer
//  ---------+-------------------------------+----------------------------------
//  item     | start, item_i, busy           | edge with start high, busy low
//  result   | digit_valid_o, result_o       | every edge with digit_valid_o high
//
// Each digit is divided out in the shared divider, which handles 8 quotient
// bits a cycle; N digits then stream out one per cycle from the digit RAM.
// A bad radix gives its single result the cycle after the transfer and
// leaves busy low. Reset is asynchronous and clears the sequencer and
// strobe; the receiver cannot stall, so results never wait.

module radix_integer_to_ascii_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ritoa_pkg::item_t   item_i,
  output logic               digit_valid_o,
  output ritoa_pkg::result_t result_o
);

  ritoa_pkg::state_e              state_q, state_d;
  logic [ritoa_pkg::ADDR_W-1:0]   wr_idx_q, wr_idx_d;
  logic [ritoa_pkg::ADDR_W-1:0]   rd_idx_q, rd_idx_d;
  logic                           strobe_q, strobe_d;
  logic                           last_q, last_d;
  logic                           bad_q, bad_d;
  logic                           upper_q;
  logic [ritoa_pkg::RADIX_W-1:0]  radix_q;

  logic                               accept, bad_in, ram_we;
  logic [ritoa_pkg::VALUE_WIDTH-1:0]  val_in, mag;
  ritoa_pkg::div_ctrl_t               div_ctrl;
  ritoa_pkg::div_status_t             div_status;
  logic [ritoa_pkg::DIGIT_W-1:0]      div_rem, ram_rdata;

  assign accept = start && !busy;
  assign busy   = (state_q != ritoa_pkg::S_IDLE);
  assign bad_in = (item_i.radix < ritoa_pkg::RADIX_MIN) ||
                  (item_i.radix > ritoa_pkg::RADIX_MAX);

  // Take the magnitude in signed mode
  assign val_in = item_i.value[ritoa_pkg::VALUE_WIDTH-1:0];
  assign mag    = (!item_i.unsigned_mode && val_in[ritoa_pkg::VALUE_WIDTH-1])
                  ? (~val_in + 1'b1) : val_in;

  ritoa_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (div_ctrl),
    .value_i  (ritoa_pkg::DIV_W'(mag)),
    .radix_i  (radix_q),
    .status_o (div_status),
    .rem_o    (div_rem)
  );

  ritoa_ram #(
    .WIDTH (ritoa_pkg::DIGIT_W),
    .DEPTH (ritoa_pkg::MAX_DIGITS)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i (div_rem),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Sequencer: divide out digits, then read them back most significant first
  always_comb begin
    state_d        = state_q;
    wr_idx_d       = wr_idx_q;
    rd_idx_d       = rd_idx_q;
    strobe_d       = 1'b0;
    last_d         = last_q;
    bad_d          = bad_q;
    ram_we         = 1'b0;
    div_ctrl.start = 1'b0;
    div_ctrl.load  = 1'b0;
    unique case (state_q)
      ritoa_pkg::S_IDLE: begin
        if (accept) begin
          if (bad_in) begin
            strobe_d = 1'b1;
            last_d   = 1'b1;
            bad_d    = 1'b1;
          end else begin
            div_ctrl.start = 1'b1;
            div_ctrl.load  = 1'b1;
            wr_idx_d       = '0;
            state_d        = ritoa_pkg::S_DIV;
          end
        end
      end
      ritoa_pkg::S_DIV: begin
        if (div_status.done) begin
          ram_we   = 1'b1;
          wr_idx_d = wr_idx_q + 1'b1;
          if (div_status.quot_zero ||
              wr_idx_q == ritoa_pkg::ADDR_W'(ritoa_pkg::MAX_DIGITS - 1)) begin
            rd_idx_d = wr_idx_q;
            state_d  = ritoa_pkg::S_EMIT;
          end else begin
            div_ctrl.start = 1'b1;
          end
        end
      end
      ritoa_pkg::S_EMIT: begin
        strobe_d = 1'b1;
        last_d   = (rd_idx_q == '0);
        bad_d    = 1'b0;
        if (rd_idx_q == '0) begin
          state_d = ritoa_pkg::S_IDLE;
        end else begin
          rd_idx_d = rd_idx_q - 1'b1;
        end
      end
      default: begin
        state_d = ritoa_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ritoa_pkg::S_IDLE;
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      strobe_q <= strobe_d;
    end
  end

  // Hold item options and result flags
  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    bad_q  <= bad_d;
    if (accept && !bad_in) begin
      upper_q <= item_i.caps;
      radix_q <= item_i.radix[ritoa_pkg::RADIX_W-1:0];
    end
  end

  assign digit_valid_o       = strobe_q;
  assign result_o.digit_char = bad_q ? ritoa_pkg::CHAR_NONE
                                     : ritoa_pkg::digit_to_ascii(ram_rdata, upper_q);
  assign result_o.last_digit = last_q;
  assign result_o.bad_radix  = bad_q;

`ifndef SYNTHESIS
  // A bad radix result is always the only and last one
  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_valid_o && result_o.bad_radix) |-> result_o.last_digit)
    else $error("bad radix result without last flag");

  // A digit strobe follows a read issued in the emit state
  a_digit_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digit_valid_o && !result_o.bad_radix) |-> $past(state_q == ritoa_pkg::S_EMIT))
    else $error("digit strobe without emit read");

  // The divider only runs while the sequencer waits for it
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.busy |-> (state_q == ritoa_pkg::S_DIV))
    else $error("divider busy outside divide state");

  // Digits never overrun the store
  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ritoa_pkg::S_DIV) |->
      (32'(wr_idx_q) < ritoa_pkg::MAX_DIGITS))
    else $error("digit index beyond store");
`endif

endmodule

// ===== bench/radix_integer_to_ascii_top_tb.sv =====
// Testbench for radix_integer_to_ascii_top: drives conversion commands, predicts
// the digit stream of each one and checks every digit transfer against it.
// Depends on ritoa_pkg and the converter RTL.
`timescale 1ns / 1ps

module radix_integer_to_ascii_top_tb;

  localparam int CLK_PERIOD   = 8;
  localparam int DRAIN_CYCLES = 700;   // idle wait after the final drain
  localparam int MAX_GAP      = 24;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  ritoa_pkg::item_t   item_i;
  logic               digit_valid_o;
  ritoa_pkg::result_t result_o;

  ritoa_pkg::result_t pending_digits[$];
  int                 error_count;

  radix_integer_to_ascii_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .item_i       (item_i),
    .digit_valid_o(digit_valid_o),
    .result_o     (result_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [6:0] got,
                                 input logic [6:0] want);
    error_count++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // Work out the digit stream of one conversion and queue it
  function automatic void queue_conversion(input ritoa_pkg::item_t it);
    logic [63:0]        mag;
    logic [63:0]        base;
    logic [3:0]         digs[64];
    logic [3:0]         d;
    ritoa_pkg::result_t r;
    int                 n;
    n = 0;
    if (it.radix < ritoa_pkg::RADIX_MIN || it.radix > ritoa_pkg::RADIX_MAX) begin
      r.digit_char = ritoa_pkg::CHAR_NONE;
      r.last_digit = 1'b1;
      r.bad_radix  = 1'b1;
      pending_digits.push_back(r);
      return;
    end
    base = {56'd0, it.radix};
    mag  = it.value;
    // signed mode converts the magnitude only
    if (!it.unsigned_mode && mag[63]) mag = ~mag + 64'd1;
    do begin
      digs[n] = 4'(mag % base);
      mag     = mag / base;
      n++;
    end while (mag != 64'd0 && n < ritoa_pkg::MAX_DIGITS);
    for (int k = 0; k < n; k++) begin
      d = digs[n - 1 - k];
      if (d < ritoa_pkg::DEC_LIMIT) r.digit_char = ritoa_pkg::CHAR_ZERO + {3'b000, d};
      else r.digit_char = (it.caps ? ritoa_pkg::CHAR_UPPER_A : ritoa_pkg::CHAR_LOWER_A)
                          + {3'b000, d} - {3'b000, ritoa_pkg::DEC_LIMIT};
      r.last_digit = (k == n - 1);
      r.bad_radix  = 1'b0;
      pending_digits.push_back(r);
    end
  endfunction

  // Check each digit transfer against the oldest expected digit
  always @(posedge clk_i) begin
    ritoa_pkg::result_t want;
    if (rst_ni && digit_valid_o === 1'b1) begin
      if (pending_digits.size() == 0) begin
        report_mismatch("unexpected digit", result_o.digit_char, ritoa_pkg::CHAR_NONE);
      end else begin
        want = pending_digits.pop_front();
        if (result_o.digit_char !== want.digit_char)
          report_mismatch("digit_char", result_o.digit_char, want.digit_char);
        if (result_o.last_digit !== want.last_digit)
          report_mismatch("last_digit", {6'd0, result_o.last_digit}, {6'd0, want.last_digit});
        if (result_o.bad_radix !== want.bad_radix)
          report_mismatch("bad_radix", {6'd0, result_o.bad_radix}, {6'd0, want.bad_radix});
      end
    end
  end

  // Present one command and hold it until the transfer
  task automatic send_item(input ritoa_pkg::item_t it);
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    queue_conversion(it);
  endtask

  // Drop start for a random gap, with junk on the item bus
  task automatic idle_sender(input int pct);
    if ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start  <= 1'b0;
      item_i <= {$urandom, $urandom, 10'($urandom)};
      repeat ($urandom_range(1, MAX_GAP)) @(negedge clk_i);
    end
  endtask

  // Hold off until every queued digit has come out
  task automatic wait_for_drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
  endtask

  function automatic ritoa_pkg::item_t make_item(input logic [63:0] v,
                                                 input logic [7:0] rdx,
                                                 input logic up, input logic uns);
    ritoa_pkg::item_t it;
    it.value         = v;
    it.radix         = rdx;
    it.caps          = up;
    it.unsigned_mode = uns;
    return it;
  endfunction

  // Mix of full-width, short, short negative and corner values
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          w;
    v = {$urandom, $urandom};
    w = $urandom_range(1, 64);
    case ($urandom_range(3))
      0: return v;
      1: return v >> (64 - w);
      2: return -(v >> (64 - w));
      default: begin
        case ($urandom_range(3))
          0: return 64'd0;
          1: return '1;
          2: return 64'h8000_0000_0000_0000;
          default: return 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // Radix outside 2..16 gives a single flagged result
  task automatic test_bad_radix();
    send_item(make_item(64'd123, 8'd0, 1'b0, 1'b1));
    send_item(make_item(64'd123, 8'd1, 1'b1, 1'b0));
    send_item(make_item('1, 8'd17, 1'b0, 1'b1));
    send_item(make_item('1, 8'd255, 1'b1, 1'b0));
  endtask

  // Largest unsigned value in every base, case flag toggling
  task automatic test_each_radix();
    for (int b = 2; b <= 16; b++) begin
      send_item(make_item('1, 8'(b), 1'(b), 1'b1));
    end
  endtask

  // Zero, most negative and other sign corners
  task automatic test_value_extremes();
    send_item(make_item(64'd0, 8'd10, 1'b0, 1'b1));
    send_item(make_item(64'd0, 8'd2, 1'b1, 1'b0));
    send_item(make_item(64'h8000_0000_0000_0000, 8'd2, 1'b0, 1'b0));
    send_item(make_item(64'h8000_0000_0000_0000, 8'd10, 1'b0, 1'b0));
    send_item(make_item('1, 8'd16, 1'b1, 1'b0));
    send_item(make_item('1, 8'd16, 1'b1, 1'b1));
    send_item(make_item(64'h7FFF_FFFF_FFFF_FFFF, 8'd8, 1'b0, 1'b0));
  endtask

  // Random commands with the given sender idle rate
  task automatic test_random_items(input int count, input int pct);
    ritoa_pkg::item_t it;
    for (int i = 0; i < count; i++) begin
      it.value         = random_value();
      it.radix         = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(2, 16));
      it.caps          = 1'($urandom);
      it.unsigned_mode = 1'($urandom);
      send_item(it);
      idle_sender(pct);
    end
  endtask

  // Stop the run if it hangs
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Reset, then run each test in turn
  initial begin
    error_count = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_bad_radix();
    test_each_radix();
    wait_for_drain();
    test_value_extremes();
    test_random_items(42, 37);
    wait_for_drain();
    test_random_items(42, 51);
    wait_for_drain();
    test_random_items(42, 0);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_digits.size() != 0)
      report_mismatch("digits never produced", 7'(pending_digits.size()), 7'd0);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== radix_integer_to_ascii_top.f =====
src/ritoa_pkg.sv
src/ritoa_ram.sv
src/ritoa_div.sv
src/radix_integer_to_ascii_top.sv
bench/radix_integer_to_ascii_top_tb.sv
